// ===== rtl/pcc_pkg.sv =====
package pcc_pkg;

  localparam logic [6:0] DUTY_MAX       = 7'd100;
  localparam logic [6:0] DUTY_DEFAULT   = 7'd50;
  localparam logic [8:0] PERIOD_MIN     = 9'd10;
  localparam logic [8:0] PERIOD_MAX     = 9'd500;
  localparam logic [8:0] PERIOD_DEFAULT = 9'd10;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_FIFO_AW    = 2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_DUTY    = 3'd1,
    OP_PERIOD  = 3'd2,
    OP_STOP    = 3'd3,
    OP_RESET   = 3'd4,
    OP_HELP    = 3'd5,
    OP_TIMEOUT = 3'd6
  } pcc_op_t;

  typedef enum logic [2:0] {
    REPLY_ACCEPTED = 3'd0,
    REPLY_NOCHANGE = 3'd1,
    REPLY_FULL     = 3'd2,
    REPLY_TIMEOUT  = 3'd3,
    REPLY_HELP     = 3'd4,
    REPLY_TICK     = 3'd5
  } pcc_reply_t;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_SETTING,
    KIND_TIMEOUT,
    KIND_HELP,
    KIND_NOCHANGE
  } pcc_kind_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] value;
  } pcc_in_t;

  typedef struct packed {
    logic [2:0] reply;
    logic       led;
    logic [1:0] queue_level;
  } pcc_out_t;

  // classified word handed from front to back, times already in ticks
  typedef struct packed {
    pcc_kind_t  kind;
    logic [8:0] on_ticks;
    logic [8:0] off_ticks;
  } pcc_cmd_t;

endpackage

// ===== rtl/pwm_command_controller_top.sv =====
// PWM generator driven by decoded commands and timer ticks. Every accepted
// word gives exactly one reply word carrying the reply code, the LED level and
// the number of pending on/off pairs. Duty and period changes are turned into
// on/off times (in ticks of MS_PER_TICK ms) by a five-stage arithmetic front
// end, then pass through a four-word queue to the back end, which owns the
// pending-pair queue (QUEUE_DEPTH entries), the position counter and the LED,
// and retires one queued word per cycle; both this and taking one input word
// every clock cycle hold while the reply side keeps up.
module pwm_command_controller_top #(
  parameter int QUEUE_DEPTH = 2,
  parameter int MS_PER_TICK = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcc_pkg::pcc_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pcc_pkg::pcc_out_t out_word
);
  import pcc_pkg::*;

  pcc_cmd_t front_cmd;
  pcc_cmd_t back_cmd;
  logic     front_valid;
  logic     fifo_full;
  logic     fifo_empty;
  logic     back_pop;

  pcc_front #(
    .MS_PER_TICK(MS_PER_TICK)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cmd_valid(front_valid),
    .cmd      (front_cmd),
    .cmd_full (fifo_full)
  );

  pcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_valid),
    .push_data(front_cmd),
    .full     (fifo_full),
    .pop      (back_pop),
    .pop_data (back_cmd),
    .empty    (fifo_empty)
  );

  pcc_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_avail(!fifo_empty),
    .cmd      (back_cmd),
    .cmd_pop  (back_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

// ===== rtl/pcc_front.sv =====
module pcc_front #(
  parameter int MS_PER_TICK = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcc_pkg::pcc_in_t  in_word,
  output logic              cmd_valid,
  output pcc_pkg::pcc_cmd_t cmd,
  input  logic              cmd_full
);
  import pcc_pkg::*;

  // reciprocal of the tick length, exact for 9-bit times
  localparam int              RECIP_SHIFT = 18;
  localparam int              RECIP_INT   = ((2 ** RECIP_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;
  localparam logic [18:0]     RECIP       = 19'(RECIP_INT);
  // ceil(2^19 / 100), estimate is never below the true quotient
  localparam logic [12:0]     PCT_RECIP   = 13'd5243;

  typedef struct packed {
    pcc_kind_t  kind;
    logic [6:0] duty;
    logic [8:0] period;
  } s1_t;

  typedef struct packed {
    pcc_kind_t   kind;
    logic [8:0]  period;
    logic [15:0] prod;
  } s2_t;

  typedef struct packed {
    pcc_kind_t   kind;
    logic [8:0]  period;
    logic [15:0] prod;
    logic [9:0]  quot;
  } s3_t;

  typedef struct packed {
    pcc_kind_t  kind;
    logic [8:0] on_ms;
    logic [8:0] off_ms;
  } s4_t;

  logic [6:0] duty_r, duty_nxt;
  logic [8:0] period_r, period_nxt;
  logic       s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  s1_t        s1_r;
  s2_t        s2_r;
  s3_t        s3_r;
  s4_t        s4_r;
  pcc_cmd_t   s5_r;
  pcc_kind_t  kind;
  logic [6:0] duty_clamp;
  logic [8:0] period_clamp;
  logic       adv, accept;
  logic [15:0] prod;
  logic [28:0] quot_mul;
  logic [16:0] quot_x100;
  logic [8:0]  on_ms, off_ms;
  logic [27:0] on_mul, off_mul;

  assign adv      = !(s5_valid_r && cmd_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    if (in_word.value < 16'sd0) begin
      duty_clamp = 7'd0;
    end else if (in_word.value > 16'sd100) begin
      duty_clamp = DUTY_MAX;
    end else begin
      duty_clamp = in_word.value[6:0];
    end
    if (in_word.value < 16'sd10) begin
      period_clamp = PERIOD_MIN;
    end else if (in_word.value > 16'sd500) begin
      period_clamp = PERIOD_MAX;
    end else begin
      period_clamp = in_word.value[8:0];
    end
  end

  always_comb begin
    duty_nxt   = duty_r;
    period_nxt = period_r;
    kind       = KIND_NOCHANGE;
    unique case (in_word.operation)
      OP_TICK: begin
        kind = KIND_TICK;
      end
      OP_DUTY: begin
        kind     = KIND_SETTING;
        duty_nxt = duty_clamp;
      end
      OP_PERIOD: begin
        kind       = KIND_SETTING;
        period_nxt = period_clamp;
      end
      OP_STOP: begin
        kind     = KIND_SETTING;
        duty_nxt = 7'd0;
      end
      OP_RESET: begin
        kind       = KIND_SETTING;
        duty_nxt   = DUTY_DEFAULT;
        period_nxt = PERIOD_DEFAULT;
      end
      OP_HELP: begin
        kind = KIND_HELP;
      end
      OP_TIMEOUT: begin
        kind = KIND_TIMEOUT;
      end
      default: begin
        kind = KIND_NOCHANGE;
      end
    endcase
  end

  // on-time = period * duty / 100 (zero for a timeout), then both times scaled to ticks
  assign prod      = 16'(s1_r.period) * 16'(s1_r.duty);
  assign quot_mul  = 29'(s2_r.prod) * 29'(PCT_RECIP);
  assign quot_x100 = {1'b0, s3_r.quot, 6'd0} + {2'b0, s3_r.quot, 5'd0}
                   + {5'b0, s3_r.quot, 2'd0};

  always_comb begin
    if (s3_r.kind == KIND_TIMEOUT) begin
      on_ms = 9'd0;
    end else if (quot_x100 > {1'b0, s3_r.prod}) begin
      on_ms = 9'(s3_r.quot - 10'd1);
    end else begin
      on_ms = s3_r.quot[8:0];
    end
    off_ms = s3_r.period - on_ms;
  end

  assign on_mul  = 28'(s4_r.on_ms) * 28'(RECIP);
  assign off_mul = 28'(s4_r.off_ms) * 28'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= DUTY_DEFAULT;
      period_r   <= PERIOD_DEFAULT;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      if (accept) begin
        duty_r   <= duty_nxt;
        period_r <= period_nxt;
      end
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.kind   <= kind;
      s1_r.duty   <= duty_nxt;
      s1_r.period <= period_nxt;
      s2_r.kind   <= s1_r.kind;
      s2_r.period <= s1_r.period;
      s2_r.prod   <= prod;
      s3_r.kind   <= s2_r.kind;
      s3_r.period <= s2_r.period;
      s3_r.prod   <= s2_r.prod;
      s3_r.quot   <= quot_mul[28:19];
      s4_r.kind   <= s3_r.kind;
      s4_r.on_ms  <= on_ms;
      s4_r.off_ms <= off_ms;
      s5_r.kind      <= s4_r.kind;
      s5_r.on_ticks  <= on_mul[26:18];
      s5_r.off_ticks <= off_mul[26:18];
    end
  end

  assign cmd_valid = s5_valid_r && !cmd_full;
  assign cmd       = s5_r;

endmodule

// ===== rtl/pcc_queue.sv =====
module pcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcc_pkg::pcc_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output pcc_pkg::pcc_cmd_t pop_data,
  output logic              empty
);
  import pcc_pkg::*;

  logic [CMD_FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_FIFO_AW:0]   count_r, count_nxt;
  pcc_cmd_t               mem_r [CMD_FIFO_DEPTH];

  assign full     = count_r == (CMD_FIFO_AW + 1)'(CMD_FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/pcc_back.sv =====
module pcc_back #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_avail,
  input  pcc_pkg::pcc_cmd_t cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output pcc_pkg::pcc_out_t out_word
);
  import pcc_pkg::*;

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [8:0]    pend_on_r  [QUEUE_DEPTH];
  logic [8:0]    pend_off_r [QUEUE_DEPTH];
  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [8:0]    active_on_r, active_on_nxt;
  logic [8:0]    active_off_r, active_off_nxt;
  logic [9:0]    position_r, position_nxt;
  logic          out_valid_r;
  pcc_out_t      out_word_r;
  pcc_out_t      result;
  logic [HW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic [9:0]    total;
  logic [10:0]   pos_inc;
  logic          wr_en;
  logic          has_room;

  assign cmd_pop  = cmd_avail && (!out_valid_r || !out_stall);
  assign has_room = count_r < CW'(QUEUE_DEPTH);
  assign tail_sum = (HW + 1)'(head_r) + (HW + 1)'(count_r);
  assign tail     = (tail_sum >= (HW + 1)'(QUEUE_DEPTH))
                  ? HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign total    = {1'b0, active_on_r} + {1'b0, active_off_r};
  assign pos_inc  = {1'b0, position_r} + 11'd1;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    active_on_nxt  = active_on_r;
    active_off_nxt = active_off_r;
    position_nxt   = position_r;
    wr_en          = 1'b0;
    result.reply   = REPLY_NOCHANGE;
    case (cmd.kind) inside
      KIND_TICK: begin
        result.reply = REPLY_TICK;
        if (pos_inc >= {1'b0, total}) begin
          position_nxt = '0;
          if (count_r != '0) begin
            active_on_nxt  = pend_on_r[head_r];
            active_off_nxt = pend_off_r[head_r];
            head_nxt       = (head_r == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt      = count_r - 1'b1;
          end
        end else begin
          position_nxt = pos_inc[9:0];
        end
      end
      KIND_SETTING, KIND_TIMEOUT: begin
        if (has_room) begin
          wr_en        = 1'b1;
          count_nxt    = count_r + 1'b1;
          result.reply = REPLY_ACCEPTED;
        end else begin
          result.reply = REPLY_FULL;
        end
        if (cmd.kind == KIND_TIMEOUT) begin
          result.reply = REPLY_TIMEOUT;
        end
      end
      KIND_HELP: begin
        result.reply = REPLY_HELP;
      end
      default: begin
        result.reply = REPLY_NOCHANGE;
      end
    endcase
    result.led         = position_nxt < {1'b0, active_on_nxt};
    result.queue_level = 2'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      active_on_r  <= 9'd0;
      active_off_r <= PERIOD_DEFAULT;
      position_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd_pop) begin
        head_r       <= head_nxt;
        count_r      <= count_nxt;
        active_on_r  <= active_on_nxt;
        active_off_r <= active_off_nxt;
        position_r   <= position_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_word_r <= result;
      if (wr_en) begin
        pend_on_r[tail]  <= cmd.on_ticks;
        pend_off_r[tail] <= cmd.off_ticks;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
